### rtl/core/cbs_pkg.sv
// shared types and constants of the cubic bezier sampler
package cbs_pkg;

   localparam int PT_W      = 16;  // coordinate width, signed
   localparam int T_W       = 17;  // curve parameter, unsigned q1.16
   localparam int COEF_W    = 21;  // polynomial coefficient width, signed
   localparam int IDX_W     = 6;   // sample index on the result channel
   localparam int SPC_W     = 7;   // samples_per_curve register width
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 17;

   // horner evaluation widths
   localparam int H1_W    = 39;    // a*t + b*2^16
   localparam int H1_LO_W = 19;    // low slice of h1, unsigned
   localparam int H2_W    = 40;    // round(h1*t + c*2^32, 16)
   localparam int H2_LO_W = 20;    // low slice of h2, unsigned
   localparam int SUM_W   = 56;    // wide accumulation before rounding
   localparam int RES_W   = SUM_W - 32;

   localparam logic [T_W-1:0] T_ONE  = 17'h10000;
   localparam logic [T_W-1:0] T_OVER = 17'h10001;

   localparam logic [CSR_DAT_W-1:0] SPC_RESET    = 17'd16;
   localparam logic [CSR_DAT_W-1:0] T_STEP_RESET = 17'd4369;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLES = 2'd0,
      CSR_T_STEP  = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } ctrl_state_type;

   typedef struct packed {
      logic             load;   // capture control points, restart t
      logic             issue;  // push one sample into the pipeline
      logic             last;   // issued sample is the final one
      logic [IDX_W-1:0] idx;
   } dp_cmd_type;

   typedef struct packed {
      logic adv;    // pipeline moves this cycle
      logic empty;  // no sample in flight or waiting at the output
   } dp_status_type;

endpackage

### rtl/core/cbs_axis_eval.sv
// five stage horner evaluator for one axis of the curve
module cbs_axis_eval (
   input  logic                               clock,
   input  logic                               adv,
   input  logic signed [cbs_pkg::COEF_W-1:0]  coef_a,
   input  logic signed [cbs_pkg::COEF_W-1:0]  coef_b,
   input  logic signed [cbs_pkg::COEF_W-1:0]  coef_c,
   input  logic signed [cbs_pkg::PT_W-1:0]    origin,
   input  logic        [cbs_pkg::T_W-1:0]     t_in,
   output logic signed [cbs_pkg::PT_W-1:0]    point
);

   localparam int SUM_W   = cbs_pkg::SUM_W;
   localparam int H1_W    = cbs_pkg::H1_W;
   localparam int H2_W    = cbs_pkg::H2_W;
   localparam int H1_LO_W = cbs_pkg::H1_LO_W;
   localparam int H2_LO_W = cbs_pkg::H2_LO_W;
   localparam int T_W     = cbs_pkg::T_W;
   localparam int ML_W    = H1_LO_W + T_W;
   localparam int MH_W    = H1_W - H1_LO_W + T_W + 1;
   localparam int NL_W    = H2_LO_W + T_W;
   localparam int NH_W    = H2_W - H2_LO_W + T_W + 1;
   localparam int RES_W   = cbs_pkg::RES_W;

   localparam logic signed [SUM_W-1:0] RND_H2 = SUM_W'(32768);
   localparam logic signed [SUM_W-1:0] RND_PT = SUM_W'(64'sd2147483648);
   localparam logic signed [RES_W-1:0] PT_MAX = RES_W'(32767);
   localparam logic signed [RES_W-1:0] PT_MIN = RES_W'(-32768);

   logic        [T_W-1:0]          t1_ff, t2_ff, t3_ff;
   logic signed [H1_W-1:0]         h1_in, h1_ff;
   logic signed [H1_W-1:0]         prod1;
   logic        [ML_W-1:0]         ml_in, ml_ff;
   logic signed [MH_W-1:0]         mh_in, mh_ff;
   logic signed [SUM_W-1:0]        sum_h2;
   logic signed [H2_W-1:0]         h2_in, h2_ff;
   logic        [NL_W-1:0]         nl_in, nl_ff;
   logic signed [NH_W-1:0]         nh_in, nh_ff;
   logic signed [SUM_W-1:0]        sum_pt;
   logic signed [RES_W-1:0]        res;
   logic signed [cbs_pkg::PT_W-1:0] point_in, point_ff;
   logic signed [T_W:0]            ts_in, t1s, t3s;
   logic signed [H1_W-H1_LO_W-1:0] h1_hi;
   logic signed [H2_W-H2_LO_W-1:0] h2_hi;

   assign ts_in = $signed({1'b0, t_in});
   assign t1s   = $signed({1'b0, t1_ff});
   assign t3s   = $signed({1'b0, t3_ff});

   // stage 1: h1 = a*t + b*2^16
   assign prod1 = coef_a * ts_in;
   assign h1_in = prod1 + (H1_W'(coef_b) <<< 16);

   // stage 2: h1*t split into two narrow products
   assign h1_hi = $signed(h1_ff[H1_W-1:H1_LO_W]);
   assign ml_in = h1_ff[H1_LO_W-1:0] * t1_ff;
   assign mh_in = h1_hi * t1s;

   // stage 3: recombine, add c, round off 16 bits
   assign sum_h2 = (SUM_W'(mh_ff) <<< H1_LO_W) + SUM_W'($signed({1'b0, ml_ff}))
                 + (SUM_W'(coef_c) <<< 32) + RND_H2;
   assign h2_in  = sum_h2[16 +: H2_W];

   // stage 4: h2*t split the same way
   assign h2_hi = $signed(h2_ff[H2_W-1:H2_LO_W]);
   assign nl_in = h2_ff[H2_LO_W-1:0] * t3_ff;
   assign nh_in = h2_hi * t3s;

   // stage 5: add p0, round off 32 bits, saturate
   assign sum_pt = (SUM_W'(nh_ff) <<< H2_LO_W) + SUM_W'($signed({1'b0, nl_ff}))
                 + (SUM_W'(origin) <<< 32) + RND_PT;
   assign res    = $signed(sum_pt[SUM_W-1:32]);

   always_comb begin
      if (res > PT_MAX) begin
         point_in = cbs_pkg::PT_W'(PT_MAX);
      end else if (res < PT_MIN) begin
         point_in = cbs_pkg::PT_W'(PT_MIN);
      end else begin
         point_in = res[cbs_pkg::PT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff    <= t_in;
         t2_ff    <= t1_ff;
         t3_ff    <= t2_ff;
         h1_ff    <= h1_in;
         ml_ff    <= ml_in;
         mh_ff    <= mh_in;
         h2_ff    <= h2_in;
         nl_ff    <= nl_in;
         nh_ff    <= nh_in;
         point_ff <= point_in;
      end
   end

   assign point = point_ff;

endmodule

### rtl/core/cbs_datapath.sv
// coefficient registers, parameter accumulator and sample pipeline
module cbs_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  cbs_pkg::dp_cmd_type                cmd,
   output cbs_pkg::dp_status_type             status,
   input  logic        [cbs_pkg::T_W-1:0]     t_step,
   input  logic signed [cbs_pkg::PT_W-1:0]    req_start_x,
   input  logic signed [cbs_pkg::PT_W-1:0]    req_start_y,
   input  logic signed [cbs_pkg::PT_W-1:0]    req_ctrl_a_x,
   input  logic signed [cbs_pkg::PT_W-1:0]    req_ctrl_a_y,
   input  logic signed [cbs_pkg::PT_W-1:0]    req_ctrl_b_x,
   input  logic signed [cbs_pkg::PT_W-1:0]    req_ctrl_b_y,
   input  logic signed [cbs_pkg::PT_W-1:0]    req_end_x,
   input  logic signed [cbs_pkg::PT_W-1:0]    req_end_y,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [cbs_pkg::PT_W-1:0]    rsp_point_x,
   output logic signed [cbs_pkg::PT_W-1:0]    rsp_point_y,
   output logic        [cbs_pkg::IDX_W-1:0]   rsp_sample_index,
   output logic                               rsp_last_sample
);

   localparam int COEF_W = cbs_pkg::COEF_W;
   localparam int PT_W   = cbs_pkg::PT_W;
   localparam int T_W    = cbs_pkg::T_W;
   localparam int DEPTH  = 5;

   typedef struct packed {
      logic [COEF_W-1:0] a;
      logic [COEF_W-1:0] b;
      logic [COEF_W-1:0] c;
   } coef_type;

   function automatic coef_type coef_calc(input logic signed [PT_W-1:0] p0,
                                          input logic signed [PT_W-1:0] p1,
                                          input logic signed [PT_W-1:0] p2,
                                          input logic signed [PT_W-1:0] p3);
      logic signed [COEF_W-1:0] e0, e1, e2, e3, d1, d2, c, b, a;
      coef_type r;
      e0 = COEF_W'(p0);
      e1 = COEF_W'(p1);
      e2 = COEF_W'(p2);
      e3 = COEF_W'(p3);
      d1 = e1 - e0;
      d2 = e2 - e1;
      c  = (d1 <<< 1) + d1;
      b  = (d2 <<< 1) + d2 - c;
      a  = e3 - e0 - c - b;
      r.a = a;
      r.b = b;
      r.c = c;
      return r;
   endfunction

   coef_type                  coef_x_in, coef_y_in;
   logic signed [COEF_W-1:0]  coef_cubic_x_ff, coef_square_x_ff, coef_linear_x_ff;
   logic signed [COEF_W-1:0]  coef_cubic_y_ff, coef_square_y_ff, coef_linear_y_ff;
   logic signed [PT_W-1:0]    origin_x_ff, origin_y_ff;
   logic        [T_W-1:0]     acc_ff, acc_in;
   logic        [T_W:0]       acc_sum;
   logic        [T_W-1:0]     t_issue;
   logic        [DEPTH-1:0]   valid_ff;
   logic        [cbs_pkg::IDX_W-1:0] idx_ff [DEPTH];
   logic        [DEPTH-1:0]   last_ff;
   logic                      adv;

   assign coef_x_in = coef_calc(req_start_x, req_ctrl_a_x, req_ctrl_b_x, req_end_x);
   assign coef_y_in = coef_calc(req_start_y, req_ctrl_a_y, req_ctrl_b_y, req_end_y);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         coef_cubic_x_ff  <= $signed(coef_x_in.a);
         coef_square_x_ff <= $signed(coef_x_in.b);
         coef_linear_x_ff <= $signed(coef_x_in.c);
         coef_cubic_y_ff  <= $signed(coef_y_in.a);
         coef_square_y_ff <= $signed(coef_y_in.b);
         coef_linear_y_ff <= $signed(coef_y_in.c);
         origin_x_ff      <= req_start_x;
         origin_y_ff      <= req_start_y;
      end
   end

   // t accumulator, pinned just above one once it passes one
   assign acc_sum = {1'b0, acc_ff} + {1'b0, t_step};
   assign acc_in  = (acc_sum > {1'b0, cbs_pkg::T_ONE}) ? cbs_pkg::T_OVER
                                                         : acc_sum[T_W-1:0];
   assign t_issue = (cmd.last || acc_ff > cbs_pkg::T_ONE) ? cbs_pkg::T_ONE : acc_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         acc_ff <= '0;
      end else if (cmd.issue) begin
         acc_ff <= acc_in;
      end
   end

   assign adv = !valid_ff[DEPTH-1] || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[DEPTH-2:0], cmd.issue};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         idx_ff[0]  <= cmd.idx;
         last_ff[0] <= cmd.last;
         for (int s = 1; s < DEPTH; s++) begin
            idx_ff[s]  <= idx_ff[s-1];
            last_ff[s] <= last_ff[s-1];
         end
      end
   end

   cbs_axis_eval u_axis_x (
      .clock  (clock),
      .adv    (adv),
      .coef_a (coef_cubic_x_ff),
      .coef_b (coef_square_x_ff),
      .coef_c (coef_linear_x_ff),
      .origin (origin_x_ff),
      .t_in   (t_issue),
      .point  (rsp_point_x)
   );

   cbs_axis_eval u_axis_y (
      .clock  (clock),
      .adv    (adv),
      .coef_a (coef_cubic_y_ff),
      .coef_b (coef_square_y_ff),
      .coef_c (coef_linear_y_ff),
      .origin (origin_y_ff),
      .t_in   (t_issue),
      .point  (rsp_point_y)
   );

   assign status.adv   = adv;
   assign status.empty = (valid_ff == '0);

   assign rsp_valid        = valid_ff[DEPTH-1];
   assign rsp_sample_index = idx_ff[DEPTH-1];
   assign rsp_last_sample  = last_ff[DEPTH-1];

endmodule

### rtl/core/cbs_ctrl.sv
// sequencer: takes a segment, issues its samples one per cycle unless stalled
module cbs_ctrl #(
   parameter int MAX_SAMPLES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [cbs_pkg::SPC_W-1:0]     samples_per_curve,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  cbs_pkg::dp_status_type        status,
   output cbs_pkg::dp_cmd_type           cmd
);

   localparam int NW = $clog2(MAX_SAMPLES + 1);
   localparam int CW = $clog2(MAX_SAMPLES);

   cbs_pkg::ctrl_state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] n_samples;
   logic [31:0]   spc_wide;
   logic          is_last;

   // clamp the count to the supported range
   assign spc_wide = 32'(samples_per_curve);
   always_comb begin
      if (spc_wide < 32'd2) begin
         n_samples = NW'(2);
      end else if (spc_wide > 32'(MAX_SAMPLES)) begin
         n_samples = NW'(MAX_SAMPLES);
      end else begin
         n_samples = NW'(spc_wide);
      end
   end

   assign is_last = (NW'(cnt_ff) == n_samples - NW'(1));

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd.load  = 1'b0;
      cmd.issue = 1'b0;
      cmd.last  = 1'b0;
      cmd.idx   = cbs_pkg::IDX_W'(cnt_ff);
      req_stall = 1'b1;
      case (state_ff)
         cbs_pkg::ST_IDLE: begin
            // next segment only once the previous one has fully drained
            req_stall = !status.empty;
            if (req_valid && status.empty) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = cbs_pkg::ST_RUN;
            end
         end
         cbs_pkg::ST_RUN: begin
            if (status.adv) begin
               cmd.issue = 1'b1;
               cmd.last  = is_last;
               if (is_last) begin
                  state_in = cbs_pkg::ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + CW'(1);
               end
            end
         end
         default: begin
            state_in = cbs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbs_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

### rtl/core/cubic_bezier_sampler_core.sv
// top level of the cubic bezier sampler
//
// req channel: one item is a cubic segment, four signed q11.4 control points
// (start, ctrl_a, ctrl_b, end), taken when req_valid is high and req_stall low.
// rsp channel: one item per sample, point_x/point_y in q11.4, rounded and
// saturated, with its sample index and a flag on the final sample.
// csr channel: always ready; index 0 is samples_per_curve (clamped to
// 2..MAX_SAMPLES), index 1 is t_step in q1.16. Other indexes are dropped.
// Write registers only while no segment is in flight.
// A segment is loaded in its accept cycle, then one sample per cycle enters a
// five stage evaluator (at most two narrow multiplies per stage and axis) unless
// rsp_stall holds the pipeline. The next segment waits until the evaluator has
// drained. When rsp_stall is high while a result waits, the whole evaluator
// holds and the result stays put.
// Reset empties the pipeline, restores samples_per_curve = 16 and
// t_step = 4369, and leaves the block ready for a segment.
module cubic_bezier_sampler_core #(
   parameter int MAX_SAMPLES = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [cbs_pkg::PT_W-1:0]      req_start_x,
   input  logic signed [cbs_pkg::PT_W-1:0]      req_start_y,
   input  logic signed [cbs_pkg::PT_W-1:0]      req_ctrl_a_x,
   input  logic signed [cbs_pkg::PT_W-1:0]      req_ctrl_a_y,
   input  logic signed [cbs_pkg::PT_W-1:0]      req_ctrl_b_x,
   input  logic signed [cbs_pkg::PT_W-1:0]      req_ctrl_b_y,
   input  logic signed [cbs_pkg::PT_W-1:0]      req_end_x,
   input  logic signed [cbs_pkg::PT_W-1:0]      req_end_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [cbs_pkg::PT_W-1:0]      rsp_point_x,
   output logic signed [cbs_pkg::PT_W-1:0]      rsp_point_y,
   output logic        [cbs_pkg::IDX_W-1:0]     rsp_sample_index,
   output logic                                 rsp_last_sample,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic        [cbs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [cbs_pkg::CSR_DAT_W-1:0] csr_data
);

   logic [cbs_pkg::SPC_W-1:0] samples_per_curve_ff;
   logic [cbs_pkg::T_W-1:0]   t_step_ff;
   cbs_pkg::dp_cmd_type       cmd;
   cbs_pkg::dp_status_type    status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         samples_per_curve_ff <= cbs_pkg::SPC_RESET[cbs_pkg::SPC_W-1:0];
         t_step_ff            <= cbs_pkg::T_STEP_RESET[cbs_pkg::T_W-1:0];
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            cbs_pkg::CSR_SAMPLES: samples_per_curve_ff <= csr_data[cbs_pkg::SPC_W-1:0];
            cbs_pkg::CSR_T_STEP:  t_step_ff            <= csr_data[cbs_pkg::T_W-1:0];
            default: begin
            end
         endcase
      end
   end

   cbs_ctrl #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .samples_per_curve (samples_per_curve_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .status            (status),
      .cmd               (cmd)
   );

   cbs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .t_step           (t_step_ff),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_ctrl_a_x     (req_ctrl_a_x),
      .req_ctrl_a_y     (req_ctrl_a_y),
      .req_ctrl_b_x     (req_ctrl_b_x),
      .req_ctrl_b_y     (req_ctrl_b_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_point_x      (rsp_point_x),
      .rsp_point_y      (rsp_point_y),
      .rsp_sample_index (rsp_sample_index),
      .rsp_last_sample  (rsp_last_sample)
   );

endmodule

### rtl/core/cbs_checker.sv
// port level checks of the cubic bezier sampler, bound to the top level
module cbs_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [cbs_pkg::PT_W-1:0]      rsp_point_x,
   input logic signed [cbs_pkg::PT_W-1:0]      rsp_point_y,
   input logic        [cbs_pkg::IDX_W-1:0]     rsp_sample_index,
   input logic                                 rsp_last_sample
);

   // out of reset the block is empty and open for a segment
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   // a segment is only taken once every earlier sample has left
   a_accept_empty: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> !rsp_valid)
      else $error("segment taken while samples still pending");

   // a taken segment closes the input until its samples are out
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input open right after a segment was taken");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_point_x)
         && $stable(rsp_point_y) && $stable(rsp_sample_index)
         && $stable(rsp_last_sample))
      else $error("stalled result changed");

endmodule

bind cubic_bezier_sampler_core cbs_checker u_checker (.*);

### tb/cubic_bezier_sampler_checker.sv
`timescale 1ns / 100ps
// checker for the bezier sampler: predicts the sample points of each segment and compares
module cubic_bezier_sampler_checker #(
   parameter int MAX_SAMPLES = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic signed [cbs_pkg::PT_W-1:0]      req_start_x,
   input  logic signed [cbs_pkg::PT_W-1:0]      req_start_y,
   input  logic signed [cbs_pkg::PT_W-1:0]      req_ctrl_a_x,
   input  logic signed [cbs_pkg::PT_W-1:0]      req_ctrl_a_y,
   input  logic signed [cbs_pkg::PT_W-1:0]      req_ctrl_b_x,
   input  logic signed [cbs_pkg::PT_W-1:0]      req_ctrl_b_y,
   input  logic signed [cbs_pkg::PT_W-1:0]      req_end_x,
   input  logic signed [cbs_pkg::PT_W-1:0]      req_end_y,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic signed [cbs_pkg::PT_W-1:0]      rsp_point_x,
   input  logic signed [cbs_pkg::PT_W-1:0]      rsp_point_y,
   input  logic        [cbs_pkg::IDX_W-1:0]     rsp_sample_index,
   input  logic                                 rsp_last_sample,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic        [cbs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [cbs_pkg::CSR_DAT_W-1:0] csr_data,
   output int                                   fail_count,
   output int                                   pending_count,
   output int                                   segment_count,
   output int                                   point_count
);

   localparam int PT_W  = cbs_pkg::PT_W;
   localparam int IDX_W = cbs_pkg::IDX_W;
   localparam int SPC_W = cbs_pkg::SPC_W;
   localparam int T_W   = cbs_pkg::T_W;

   typedef struct packed {
      logic signed [PT_W-1:0]  point_x;
      logic signed [PT_W-1:0]  point_y;
      logic        [IDX_W-1:0] sample_index;
      logic                    last_sample;
   } curve_point_type;

   localparam longint Q32_ONE  = 64'sh1_0000_0000;
   localparam longint Q32_HALF = 64'sh8000_0000;
   localparam longint Q16_HALF = 64'sh8000;
   localparam longint COORD_HI = 32767;
   localparam longint COORD_LO = -32768;

   // register copies
   logic [SPC_W-1:0] samples_reg;
   logic [T_W-1:0]   t_step_reg;

   // coefficients and origin of the last segment, x then y
   longint cubic_coef[2];
   longint square_coef[2];
   longint linear_coef[2];
   longint origin[2];
   longint ctrl_pt[2][4];

   curve_point_type expected_points[$];
   curve_point_type want;
   logic            mismatch;

   // horner form, t in q1.16, round half up, saturate to the coordinate range
   function automatic logic signed [PT_W-1:0] bezier_axis_point(
      input longint a, input longint b, input longint c, input longint p0, input longint t
   );
      longint h1;
      longint h2;
      longint r;
      h1 = a * t + b * 65536;
      h2 = (h1 * t + c * Q32_ONE + Q16_HALF) >>> 16;
      r  = (h2 * t + p0 * Q32_ONE + Q32_HALF) >>> 32;
      if (r > COORD_HI) r = COORD_HI;
      else if (r < COORD_LO) r = COORD_LO;
      return r[PT_W-1:0];
   endfunction

   task automatic predict_curve_points();
      int unsigned     count;
      longint          tt;
      curve_point_type pt;
      for (int k = 0; k < 2; k++) begin
         linear_coef[k] = 3 * (ctrl_pt[k][1] - ctrl_pt[k][0]);
         square_coef[k] = 3 * (ctrl_pt[k][2] - ctrl_pt[k][1]) - linear_coef[k];
         cubic_coef[k]  = ctrl_pt[k][3] - ctrl_pt[k][0] - linear_coef[k] - square_coef[k];
         origin[k]      = ctrl_pt[k][0];
      end
      count = 32'(samples_reg);
      if (count < 2) count = 2;
      if (count > MAX_SAMPLES) count = MAX_SAMPLES;
      for (int unsigned i = 0; i < count; i++) begin
         tt = longint'(i) * longint'(t_step_reg);
         // final sample pinned to t = 1, earlier ones saturate there
         if (i == count - 1 || tt > longint'(cbs_pkg::T_ONE)) tt = longint'(cbs_pkg::T_ONE);
         pt.point_x = bezier_axis_point(cubic_coef[0], square_coef[0], linear_coef[0],
                                        origin[0], tt);
         pt.point_y = bezier_axis_point(cubic_coef[1], square_coef[1], linear_coef[1],
                                        origin[1], tt);
         pt.sample_index = i[IDX_W-1:0];
         pt.last_sample  = (i == count - 1);
         expected_points.push_back(pt);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         samples_reg = cbs_pkg::SPC_RESET[SPC_W-1:0];
         t_step_reg  = cbs_pkg::T_STEP_RESET;
         expected_points.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == cbs_pkg::CSR_SAMPLES) samples_reg = csr_data[SPC_W-1:0];
            else if (csr_index == cbs_pkg::CSR_T_STEP) t_step_reg = csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            point_count++;
            if (expected_points.size() == 0) begin
               fail_count++;
               $error("unexpected point item: x %0d y %0d index %0d last %0d",
                      rsp_point_x, rsp_point_y, rsp_sample_index, rsp_last_sample);
            end else begin
               want = expected_points.pop_front();
               mismatch = 1'b0;
               if (rsp_point_x !== want.point_x) begin
                  mismatch = 1'b1;
                  $error("point_x: expected %0d, got %0d", want.point_x, rsp_point_x);
               end
               if (rsp_point_y !== want.point_y) begin
                  mismatch = 1'b1;
                  $error("point_y: expected %0d, got %0d", want.point_y, rsp_point_y);
               end
               if (rsp_sample_index !== want.sample_index) begin
                  mismatch = 1'b1;
                  $error("sample_index: expected %0d, got %0d",
                         want.sample_index, rsp_sample_index);
               end
               if (rsp_last_sample !== want.last_sample) begin
                  mismatch = 1'b1;
                  $error("last_sample: expected %0d, got %0d",
                         want.last_sample, rsp_last_sample);
               end
               if (mismatch) fail_count++;
            end
         end
         if (req_valid && !req_stall) begin
            segment_count++;
            ctrl_pt[0][0] = longint'(req_start_x);
            ctrl_pt[0][1] = longint'(req_ctrl_a_x);
            ctrl_pt[0][2] = longint'(req_ctrl_b_x);
            ctrl_pt[0][3] = longint'(req_end_x);
            ctrl_pt[1][0] = longint'(req_start_y);
            ctrl_pt[1][1] = longint'(req_ctrl_a_y);
            ctrl_pt[1][2] = longint'(req_ctrl_b_y);
            ctrl_pt[1][3] = longint'(req_end_y);
            predict_curve_points();
         end
      end
      pending_count = expected_points.size();
   end

endmodule

### tb/cubic_bezier_sampler_core_tb.sv
`timescale 1ns / 100ps
// testbench top for the bezier sampler: stimulus, idling patterns and verdict
module cubic_bezier_sampler_core_tb;

   localparam int PT_W      = cbs_pkg::PT_W;
   localparam int IDX_W     = cbs_pkg::IDX_W;
   localparam int CSR_IDX_W = cbs_pkg::CSR_IDX_W;
   localparam int CSR_DAT_W = cbs_pkg::CSR_DAT_W;

   localparam int CLK_PERIOD      = 8;
   localparam int MAX_SAMPLES     = 64;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int DRAIN_TAIL      = 16;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 32;

   // register indexes with nothing behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   localparam logic signed [PT_W-1:0] COORD_MIN = 16'sh8000;
   localparam logic signed [PT_W-1:0] COORD_MAX = 16'sh7FFF;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_type;
   typedef enum {SHAPE_ANY, SHAPE_LOCAL, SHAPE_EXTREME} segment_shape_type;

   typedef struct packed {
      logic signed [PT_W-1:0] start_x;
      logic signed [PT_W-1:0] start_y;
      logic signed [PT_W-1:0] ctrl_a_x;
      logic signed [PT_W-1:0] ctrl_a_y;
      logic signed [PT_W-1:0] ctrl_b_x;
      logic signed [PT_W-1:0] ctrl_b_y;
      logic signed [PT_W-1:0] end_x;
      logic signed [PT_W-1:0] end_y;
   } segment_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic signed [PT_W-1:0]  req_start_x;
   logic signed [PT_W-1:0]  req_start_y;
   logic signed [PT_W-1:0]  req_ctrl_a_x;
   logic signed [PT_W-1:0]  req_ctrl_a_y;
   logic signed [PT_W-1:0]  req_ctrl_b_x;
   logic signed [PT_W-1:0]  req_ctrl_b_y;
   logic signed [PT_W-1:0]  req_end_x;
   logic signed [PT_W-1:0]  req_end_y;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic signed [PT_W-1:0]  rsp_point_x;
   logic signed [PT_W-1:0]  rsp_point_y;
   logic [IDX_W-1:0]        rsp_sample_index;
   logic                    rsp_last_sample;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DAT_W-1:0]    csr_data;

   int fail_count;
   int pending_count;
   int segment_count;
   int point_count;
   int settings_count;
   int send_idle_pct;
   int stall_pct;
   int idle_cycles;

   always #(CLK_PERIOD / 2) clock = ~clock;

   cubic_bezier_sampler_core #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_ctrl_a_x     (req_ctrl_a_x),
      .req_ctrl_a_y     (req_ctrl_a_y),
      .req_ctrl_b_x     (req_ctrl_b_x),
      .req_ctrl_b_y     (req_ctrl_b_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_point_x      (rsp_point_x),
      .rsp_point_y      (rsp_point_y),
      .rsp_sample_index (rsp_sample_index),
      .rsp_last_sample  (rsp_last_sample),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   cubic_bezier_sampler_checker #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_ctrl_a_x     (req_ctrl_a_x),
      .req_ctrl_a_y     (req_ctrl_a_y),
      .req_ctrl_b_x     (req_ctrl_b_x),
      .req_ctrl_b_y     (req_ctrl_b_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_point_x      (rsp_point_x),
      .rsp_point_y      (rsp_point_y),
      .rsp_sample_index (rsp_sample_index),
      .rsp_last_sample  (rsp_last_sample),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .segment_count    (segment_count),
      .point_count      (point_count)
   );

   // receiver back-pressure
   always @(negedge clock) begin
      if (!reset) rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // ends a run in which no channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic set_idling(input idling_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 80;
            stall_pct     = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            stall_pct     = 80;
         end
         default: begin
            send_idle_pct = 8;
            stall_pct     = 8;
         end
      endcase
   endtask

   // drops req_valid and holds until every predicted point has come back
   task automatic wait_points_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] reg_index,
                            input logic [CSR_DAT_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = reg_index;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic apply_settings(input logic [CSR_DAT_W-1:0] samples,
                                 input logic [CSR_DAT_W-1:0] step);
      wait_points_drained();
      write_csr(cbs_pkg::CSR_SAMPLES, samples);
      write_csr(cbs_pkg::CSR_T_STEP, step);
      settings_count++;
   endtask

   // valid stays high after the handshake so back-to-back items keep flowing
   task automatic send_segment(input segment_type seg);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      {req_start_x, req_start_y, req_ctrl_a_x, req_ctrl_a_y,
       req_ctrl_b_x, req_ctrl_b_y, req_end_x, req_end_y} = seg;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic signed [PT_W-1:0] pick_coord(input segment_shape_type shape,
                                                         input logic signed [PT_W-1:0] base);
      int unsigned pick;
      pick = $urandom_range(3);
      if (shape == SHAPE_ANY) return PT_W'($urandom);
      if (shape == SHAPE_LOCAL) return PT_W'(base + $urandom_range(4095) - 2048);
      if (pick == 0) return COORD_MIN;
      if (pick == 1) return COORD_MAX;
      if (pick == 2) return '0;
      return PT_W'($urandom);
   endfunction

   function automatic segment_type random_segment();
      segment_type            seg;
      segment_shape_type      shape;
      logic signed [PT_W-1:0] base_x;
      logic signed [PT_W-1:0] base_y;
      shape  = segment_shape_type'($urandom_range(2));
      base_x = PT_W'($urandom_range(16000) - 8000);
      base_y = PT_W'($urandom_range(16000) - 8000);
      seg.start_x  = pick_coord(shape, base_x);
      seg.start_y  = pick_coord(shape, base_y);
      seg.ctrl_a_x = pick_coord(shape, base_x);
      seg.ctrl_a_y = pick_coord(shape, base_y);
      seg.ctrl_b_x = pick_coord(shape, base_x);
      seg.ctrl_b_y = pick_coord(shape, base_y);
      seg.end_x    = pick_coord(shape, base_x);
      seg.end_y    = pick_coord(shape, base_y);
      return seg;
   endfunction

   initial begin : stimulus
      int unsigned n;
      int unsigned eff;
      int unsigned step;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_start_x  = '0;
      req_start_y  = '0;
      req_ctrl_a_x = '0;
      req_ctrl_a_y = '0;
      req_ctrl_b_x = '0;
      req_ctrl_b_y = '0;
      req_end_x    = '0;
      req_end_y    = '0;
      rsp_stall    = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = cbs_pkg::CSR_SAMPLES;
      csr_data     = '0;
      settings_count = 1;
      set_idling(IDLE_NONE);
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // reset register values: 16 samples, step 4369
      send_segment(segment_type'{default: '0});
      send_segment(segment_type'{default: COORD_MAX});
      send_segment(segment_type'{default: COORD_MIN});
      // control polygon zigzag between the coordinate extremes
      send_segment(segment_type'{COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                                 COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN});
      send_segment(segment_type'{COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                                 COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX});
      // collinear evenly spaced points
      send_segment(segment_type'{-16'sd300, 16'sd90, -16'sd100, 16'sd30,
                                 16'sd100, -16'sd30, 16'sd300, -16'sd90});
      // tiny values where rounding halves show up
      send_segment(segment_type'{16'sd1, -16'sd1, 16'sd2, -16'sd3,
                                 -16'sd5, 16'sd7, 16'sd3, -16'sd2});

      // two samples, endpoints only
      apply_settings(2, 65536);
      send_segment(random_segment());
      send_segment(random_segment());
      // sample count below range, clamped up
      apply_settings(0, 1);
      send_segment(random_segment());
      // all data bits set: 127 samples clamps to the maximum
      apply_settings(17'h1FFFF, 1040);
      send_segment(random_segment());
      send_segment(random_segment());
      // zero step: everything at t = 0 but the last
      apply_settings(CSR_DAT_W'(MAX_SAMPLES), 0);
      send_segment(random_segment());
      // largest step, parameter saturates from the second sample
      apply_settings(5, 17'h1FFFF);
      send_segment(random_segment());
      // parameter passes one partway along the curve
      apply_settings(9, 30000);
      send_segment(random_segment());
      apply_settings(CSR_DAT_W'(MAX_SAMPLES + 1), 1057);
      send_segment(random_segment());
      // writes to unmapped indexes must leave both registers alone
      wait_points_drained();
      write_csr(CSR_SPARE_2, CSR_DAT_W'($urandom));
      write_csr(CSR_SPARE_3, 17'h1FFFF);
      send_segment(random_segment());
      apply_settings(1, 65536);
      send_segment(random_segment());

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case ($urandom_range(5))
            0:       n = MAX_SAMPLES;
            1:       n = $urandom_range(127, MAX_SAMPLES + 1);
            default: n = $urandom_range(20, 0);
         endcase
         eff  = (n < 2) ? 2 : ((n > MAX_SAMPLES) ? MAX_SAMPLES : n);
         step = ($urandom_range(3) == 0) ? $urandom_range(17'h1FFFF, 0)
                                         : (65536 + (eff - 1) / 2) / (eff - 1);
         apply_settings(CSR_DAT_W'(n), CSR_DAT_W'(step));
         set_idling(idling_type'(ph % 4));
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            // sender holds off until the block has drained
            if ((ph == 1 && k == ITEMS_PER_PHASE / 2) || $urandom_range(24) == 0) begin
               wait_points_drained();
            end
            send_segment(random_segment());
         end
      end

      wait_points_drained();
      repeat (DRAIN_TAIL) @(posedge clock);
      $display("checked %0d segments and %0d sample points under %0d register settings",
               segment_count, point_count, settings_count);
      $display("incl. clamped counts, zero and oversized steps, sender and receiver idling");
      if (fail_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/cbs_pkg.sv
rtl/core/cbs_axis_eval.sv
rtl/core/cbs_datapath.sv
rtl/core/cbs_ctrl.sv
rtl/core/cubic_bezier_sampler_core.sv
rtl/core/cbs_checker.sv
tb/cubic_bezier_sampler_checker.sv
tb/cubic_bezier_sampler_core_tb.sv
